@@ design/srrw_pkg.sv @@
// ----------------------------------------------------------------------------
// srrw_pkg: shared types and constants for the selective repeat receive window
// Result kind codes, register indexes, parameter defaults and the command and
// status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package srrw_pkg;

  localparam int WINDOW_MAX_DEF  = 16;
  localparam int PAYLOAD_MAX_DEF = 128;

  localparam int SEQ_W   = 16;
  localparam int SIZE_W  = 8;
  localparam int TAG_W   = 16;
  localparam int WCFG_W  = 5;
  localparam int NEXP_W  = SEQ_W + 1;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [WCFG_W-1:0] WINDOW_SIZE_RST = 5'd4;
  localparam logic [SEQ_W-1:0]  LAST_SEQ_RST    = 16'd0;

  localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LAST_SEQ    = 2'd1;

  typedef enum logic [1:0] {
    KIND_STORED  = 2'd0,
    KIND_DUP     = 2'd1,
    KIND_REJECT  = 2'd2,
    KIND_DELIVER = 2'd3
  } kind_t;

  typedef struct packed {
    logic cap;       // capture an arriving request
    logic ack_load;  // load the acknowledge/reject result, commit a store
    logic del_load;  // load one in-order delivery, advance the base
  } cmd_t;

  typedef struct packed {
    logic out_free;  // result register empty or being drained
    logic ack_more;  // a delivery follows the acknowledge
    logic del_more;  // another delivery follows this one
  } status_t;

endpackage

@@ design/srrw_ctrl.sv @@
// ----------------------------------------------------------------------------
// srrw_ctrl: sequencing controller
// Steps each request through capture, classification and the release run.
// ----------------------------------------------------------------------------
module srrw_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             pkt_valid,
  output logic             pkt_ready,
  input  srrw_pkg::status_t sts,
  output srrw_pkg::cmd_t    cmd
);
  import srrw_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE    = 3'b001,
    S_CLASS   = 3'b010,
    S_DELIVER = 3'b100
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign pkt_ready = (state == S_IDLE);

  always_comb begin
    state_next   = state;
    cmd.cap      = 1'b0;
    cmd.ack_load = 1'b0;
    cmd.del_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (pkt_valid) begin
          cmd.cap    = 1'b1;
          state_next = S_CLASS;
        end
      end
      S_CLASS: begin
        // hold until the result register can take the acknowledge
        if (sts.out_free) begin
          cmd.ack_load = 1'b1;
          state_next   = sts.ack_more ? S_DELIVER : S_IDLE;
        end
      end
      S_DELIVER: begin
        if (sts.out_free) begin
          cmd.del_load = 1'b1;
          state_next   = sts.del_more ? S_DELIVER : S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

@@ design/srrw_datapath.sv @@
// ----------------------------------------------------------------------------
// srrw_datapath: window state, slot store and result register
// Classifies the captured request, stores it by slot, and releases stored
// packets from the base through a registered slot memory read.
// ----------------------------------------------------------------------------
module srrw_datapath #(
  parameter int WINDOW_MAX  = srrw_pkg::WINDOW_MAX_DEF,
  parameter int PAYLOAD_MAX = srrw_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srrw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic [srrw_pkg::SEQ_W-1:0]        seq_num,
  input  logic [srrw_pkg::SIZE_W-1:0]       payload_size,
  input  logic [srrw_pkg::TAG_W-1:0]        payload_tag,
  input  logic                              res_ready,
  output logic                              res_valid,
  output logic [1:0]                        kind,
  output logic [srrw_pkg::SEQ_W-1:0]        seq_out,
  output logic [srrw_pkg::SIZE_W-1:0]       size_out,
  output logic [srrw_pkg::TAG_W-1:0]        tag_out,
  output logic                              all_done,
  output logic                              last,
  input  srrw_pkg::cmd_t                    cmd,
  output srrw_pkg::status_t                 sts
);
  import srrw_pkg::*;

  localparam int SW    = $clog2(WINDOW_MAX);
  localparam int ENT_W = SIZE_W + TAG_W;
  localparam logic [SW:0]       WMAX_S   = (SW + 1)'(WINDOW_MAX);
  localparam logic [SW-1:0]     SLOT_TOP = SW'(WINDOW_MAX - 1);
  localparam logic [NEXP_W:0]   WMAX_W   = (NEXP_W + 1)'(WINDOW_MAX);
  localparam logic [SIZE_W-1:0] PMAX_S   = SIZE_W'(PAYLOAD_MAX);

  // configuration registers
  logic [WCFG_W-1:0] window_size;
  logic [SEQ_W-1:0]  last_seq;

  always_ff @(posedge clk) begin
    if (rst) begin
      window_size <= WINDOW_SIZE_RST;
      last_seq    <= LAST_SEQ_RST;
    end else if (cfg_we) begin
      if (cfg_index == REG_WINDOW_SIZE) begin
        window_size <= cfg_data[WCFG_W-1:0];
      end else if (cfg_index == REG_LAST_SEQ) begin
        last_seq <= cfg_data[SEQ_W-1:0];
      end
    end
  end

  // captured request, size saturated on the way in
  logic [SEQ_W-1:0]  seq_q;
  logic [SIZE_W-1:0] size_q;
  logic [TAG_W-1:0]  tag_q;
  logic              size_over;

  assign size_over = 32'(payload_size) > 32'(PAYLOAD_MAX);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      seq_q  <= seq_num;
      size_q <= size_over ? PMAX_S : payload_size;
      tag_q  <= payload_tag;
    end
  end

  // window base
  logic [NEXP_W-1:0] ne, ne_inc;
  logic [SW-1:0]     ne_slot, ne_slot_inc;
  logic [WINDOW_MAX-1:0] slot_valid;

  assign ne_inc      = ne + NEXP_W'(1);
  assign ne_slot_inc = (ne_slot == SLOT_TOP) ? '0 : ne_slot + SW'(1);

  // classification
  logic [NEXP_W-1:0] seq_x, last_x, diff;
  logic [NEXP_W:0]   weff, top;
  logic [SW:0]       wsum;
  logic [SW-1:0]     wslot;
  kind_t             ack_kind;
  logic              store;

  assign seq_x  = {1'b0, seq_q};
  assign last_x = {1'b0, last_seq};
  assign diff   = seq_x - ne;
  assign wsum   = {1'b0, ne_slot} + {1'b0, diff[SW-1:0]};
  // offset from base stays below the slot count, so one subtract wraps it
  assign wslot  = (wsum >= WMAX_S) ? SW'(wsum - WMAX_S) : wsum[SW-1:0];

  always_comb begin
    if (window_size == '0) begin
      weff = (NEXP_W + 1)'(1);
    end else if ((NEXP_W + 1)'(window_size) > WMAX_W) begin
      weff = WMAX_W;
    end else begin
      weff = (NEXP_W + 1)'(window_size);
    end
  end

  assign top = {1'b0, ne} + weff;

  always_comb begin
    priority if (seq_q > last_seq) begin
      ack_kind = KIND_REJECT;
    end else if (seq_x < ne) begin
      ack_kind = KIND_DUP;
    end else if ({1'b0, seq_x} >= top) begin
      ack_kind = KIND_REJECT;
    end else if (slot_valid[wslot]) begin
      ack_kind = KIND_DUP;
    end else begin
      ack_kind = KIND_STORED;
    end
  end

  assign store = (ack_kind == KIND_STORED);

  assign sts.out_free = !res_valid || res_ready;
  assign sts.ack_more = (ne <= last_x) &&
                        (slot_valid[ne_slot] || (store && (wslot == ne_slot)));
  assign sts.del_more = (ne_inc <= last_x) && slot_valid[ne_slot_inc];

  always_ff @(posedge clk) begin
    if (rst) begin
      ne         <= '0;
      ne_slot    <= '0;
      slot_valid <= '0;
    end else begin
      if (cmd.ack_load && store) begin
        slot_valid[wslot] <= 1'b1;
      end
      if (cmd.del_load) begin
        slot_valid[ne_slot] <= 1'b0;
        ne                  <= ne_inc;
        ne_slot             <= ne_slot_inc;
      end
    end
  end

  // slot memory: one write port, one registered read at the base slot
  logic [ENT_W-1:0] slot_mem [WINDOW_MAX];
  logic [ENT_W-1:0] rd_data, del_data;
  logic [SW-1:0]    rd_addr;
  logic             byp;

  assign rd_addr = cmd.del_load ? ne_slot_inc : ne_slot;

  always_ff @(posedge clk) begin
    if (cmd.ack_load && store) begin
      slot_mem[wslot] <= {size_q, tag_q};
    end
    rd_data <= slot_mem[rd_addr];
  end

  // a store to the base slot is not yet visible to the read in that cycle
  always_ff @(posedge clk) begin
    if (rst) begin
      byp <= 1'b0;
    end else if (cmd.ack_load) begin
      byp <= store && (wslot == ne_slot);
    end else if (cmd.del_load) begin
      byp <= 1'b0;
    end
  end

  assign del_data = byp ? {size_q, tag_q} : rd_data;

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.ack_load || cmd.del_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.ack_load) begin
      kind     <= ack_kind;
      seq_out  <= seq_q;
      size_out <= '0;
      tag_out  <= '0;
      all_done <= ne > last_x;
      last     <= !sts.ack_more;
    end else if (cmd.del_load) begin
      kind     <= KIND_DELIVER;
      seq_out  <= ne[SEQ_W-1:0];
      size_out <= del_data[ENT_W-1:TAG_W];
      tag_out  <= del_data[TAG_W-1:0];
      all_done <= ne_inc > last_x;
      last     <= !sts.del_more;
    end
  end

endmodule

@@ design/selective_repeat_receive_window.sv @@
// ----------------------------------------------------------------------------
// selective_repeat_receive_window: receive side of a selective repeat link
// Acknowledges, stores or rejects packet descriptors and releases the
// consecutive stored run from the window base in order.
// ----------------------------------------------------------------------------
//   channel | handshake             | payload
//   pkt     | pkt_valid/pkt_ready   | seq_num, payload_size, payload_tag
//   res     | res_valid/res_ready   | kind, seq_out, size_out, tag_out,
//           |                       | all_done, last
//   cfg     | cfg_we                | cfg_index, cfg_data
//
// A request passes through capture and classification; the release walk then
// loads one packet at a time, set by the one-read slot memory and the single
// result register. Reset is synchronous and clears the base and the slot
// valid bits; slot contents need no clearing. A stalled result register holds
// the controller; the next request is taken once the last result is loaded.
// ----------------------------------------------------------------------------
module selective_repeat_receive_window #(
  parameter int WINDOW_MAX  = srrw_pkg::WINDOW_MAX_DEF,
  parameter int PAYLOAD_MAX = srrw_pkg::PAYLOAD_MAX_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_we,
  input  logic [srrw_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [srrw_pkg::CFG_DATA_W-1:0]   cfg_data,
  input  logic                              pkt_valid,
  output logic                              pkt_ready,
  input  logic [srrw_pkg::SEQ_W-1:0]        seq_num,
  input  logic [srrw_pkg::SIZE_W-1:0]       payload_size,
  input  logic [srrw_pkg::TAG_W-1:0]        payload_tag,
  output logic                              res_valid,
  input  logic                              res_ready,
  output logic [1:0]                        kind,
  output logic [srrw_pkg::SEQ_W-1:0]        seq_out,
  output logic [srrw_pkg::SIZE_W-1:0]       size_out,
  output logic [srrw_pkg::TAG_W-1:0]        tag_out,
  output logic                              all_done,
  output logic                              last
);
  import srrw_pkg::*;

  cmd_t    cmd;
  status_t sts;

  srrw_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .pkt_valid (pkt_valid),
    .pkt_ready (pkt_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  srrw_datapath #(
    .WINDOW_MAX  (WINDOW_MAX),
    .PAYLOAD_MAX (PAYLOAD_MAX)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .seq_num      (seq_num),
    .payload_size (payload_size),
    .payload_tag  (payload_tag),
    .res_ready    (res_ready),
    .res_valid    (res_valid),
    .kind         (kind),
    .seq_out      (seq_out),
    .size_out     (size_out),
    .tag_out      (tag_out),
    .all_done     (all_done),
    .last         (last),
    .cmd          (cmd),
    .sts          (sts)
  );

endmodule

@@ verif/testbench.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: selective repeat receive window
// Sends packet descriptors through the valid/ready request channel, predicts
// the acknowledge, reject and in-order delivery results of each one with a
// local copy of the window state, and compares every result field by field.
// ----------------------------------------------------------------------------
module testbench;
  import srrw_pkg::*;

  localparam int WINDOW_DEPTH  = WINDOW_MAX_DEF;
  localparam int PAYLOAD_LIMIT = PAYLOAD_MAX_DEF;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

  typedef struct {
    kind_t             kind;
    logic [SEQ_W-1:0]  seq;
    logic [SIZE_W-1:0] size;
    logic [TAG_W-1:0]  tag;
    logic              done;
    logic              fin;
  } rx_result_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  logic                  pkt_valid = 1'b0;
  logic                  pkt_ready;
  logic [SEQ_W-1:0]      seq_num = '0;
  logic [SIZE_W-1:0]     payload_size = '0;
  logic [TAG_W-1:0]      payload_tag = '0;
  logic                  res_valid;
  logic                  res_ready = 1'b0;
  logic [1:0]            kind;
  logic [SEQ_W-1:0]      seq_out;
  logic [SIZE_W-1:0]     size_out;
  logic [TAG_W-1:0]      tag_out;
  logic                  all_done;
  logic                  last;

  // window state as the block should hold it
  logic [WCFG_W-1:0]  win_cfg;
  logic [SEQ_W-1:0]   last_cfg;
  logic [NEXP_W-1:0]  base_seq;
  logic               held [WINDOW_DEPTH];
  logic [SIZE_W-1:0]  held_size [WINDOW_DEPTH];
  logic [TAG_W-1:0]   held_tag [WINDOW_DEPTH];

  rx_result_t pending_results[$];
  int         mismatches = 0;
  bit         calm = 1'b0;

  selective_repeat_receive_window dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .pkt_valid    (pkt_valid),
    .pkt_ready    (pkt_ready),
    .seq_num      (seq_num),
    .payload_size (payload_size),
    .payload_tag  (payload_tag),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .kind         (kind),
    .seq_out      (seq_out),
    .size_out     (size_out),
    .tag_out      (tag_out),
    .all_done     (all_done),
    .last         (last)
  );

  always #4 clk = ~clk;

  initial begin
    #2000000;
    $display("simulation failed");
    $finish;
  end

  always @(posedge clk) begin
    res_ready <= calm || ($urandom_range(99) >= 6);
  end

  function automatic int window_span(input logic [WCFG_W-1:0] w);
    if (w == 0) return 1;
    if (w > WINDOW_DEPTH) return WINDOW_DEPTH;
    return int'(w);
  endfunction

  task automatic predict_packet(input logic [SEQ_W-1:0] s, input logic [SIZE_W-1:0] sz_in,
                                input logic [TAG_W-1:0] tg);
    rx_result_t r;
    logic [SIZE_W-1:0] sz;
    int span;
    int slot;
    int n;
    sz = (sz_in > PAYLOAD_LIMIT) ? SIZE_W'(PAYLOAD_LIMIT) : sz_in;
    span = window_span(win_cfg);
    slot = s % WINDOW_DEPTH;
    r.seq = s;
    r.size = '0;
    r.tag = '0;
    r.fin = 1'b0;
    if (s > last_cfg) r.kind = KIND_REJECT;
    else if (s < base_seq) r.kind = KIND_DUP;
    else if (s >= base_seq + span) r.kind = KIND_REJECT;
    else if (held[slot]) r.kind = KIND_DUP;
    else begin
      held[slot] = 1'b1;
      held_size[slot] = sz;
      held_tag[slot] = tg;
      r.kind = KIND_STORED;
    end
    r.done = base_seq > last_cfg;
    pending_results.push_back(r);
    n = 1;
    // release the consecutive stored run from the base
    while (n <= WINDOW_DEPTH && base_seq <= last_cfg) begin
      slot = base_seq % WINDOW_DEPTH;
      if (!held[slot]) break;
      held[slot] = 1'b0;
      r.kind = KIND_DELIVER;
      r.seq = base_seq[SEQ_W-1:0];
      r.size = held_size[slot];
      r.tag = held_tag[slot];
      base_seq = base_seq + 1'b1;
      r.done = base_seq > last_cfg;
      pending_results.push_back(r);
      n++;
    end
    pending_results[pending_results.size()-1].fin = 1'b1;
  endtask

  task automatic check_field(input string name, input int expv, input int gotv);
    if (expv != gotv) begin
      $display("%0t ns: %s expected 0x%0h, got 0x%0h", $time, name, expv, gotv);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin : monitor
    rx_result_t want;
    if (!rst) begin
      if (pkt_valid && pkt_ready) predict_packet(seq_num, payload_size, payload_tag);
      if (res_valid && res_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t ns: result expected none, got kind %0d seq 0x%0h",
                   $time, kind, seq_out);
          mismatches++;
        end else begin
          want = pending_results.pop_front();
          check_field("kind", int'(want.kind), int'(kind));
          check_field("seq_out", int'(want.seq), int'(seq_out));
          check_field("size_out", int'(want.size), int'(size_out));
          check_field("tag_out", int'(want.tag), int'(tag_out));
          check_field("all_done", int'(want.done), int'(all_done));
          check_field("last", int'(want.fin), int'(last));
        end
      end
    end
  end

  task automatic send_packet(input logic [SEQ_W-1:0] s, input logic [SIZE_W-1:0] sz,
                             input logic [TAG_W-1:0] tg);
    if (!calm && $urandom_range(99) < 6) begin
      pkt_valid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    pkt_valid <= 1'b1;
    seq_num <= s;
    payload_size <= sz;
    payload_tag <= tg;
    do @(posedge clk); while (!pkt_ready);
  endtask

  // hold requests until every result has drained
  task automatic go_idle();
    pkt_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WINDOW_SIZE) win_cfg = value[WCFG_W-1:0];
    else if (idx == REG_LAST_SEQ) last_cfg = value;
    @(posedge clk);
  endtask

  task automatic test_reset_state();
    send_packet(16'd0, 8'd0, 16'd0);
    send_packet(16'd0, 8'd7, 16'h1234);
    send_packet(16'd1, 8'd1, 16'h0001);
    send_packet(16'hFFFF, 8'hFF, 16'hFFFF);
    go_idle();
  endtask

  task automatic test_window_limits();
    write_reg(REG_LAST_SEQ, 16'd100);
    write_reg(REG_WINDOW_SIZE, 16'd0);
    send_packet(16'd2, 8'd10, 16'h0202);
    send_packet(16'd1, 8'hFF, 16'hFFFF);
    go_idle();
    write_reg(REG_WINDOW_SIZE, 16'hFFFF);
    send_packet(16'd18, 8'd5, 16'h1818);
    send_packet(16'd17, 8'd129, 16'hA5A5);
    send_packet(16'd17, 8'd3, 16'h5A5A);
    send_packet(16'd1, 8'd4, 16'h0101);
    go_idle();
    write_reg(REG_WINDOW_SIZE, 16'd16);
    send_packet(16'd2, 8'd128, 16'h8001);
    go_idle();
  endtask

  task automatic test_last_seq_lowered();
    send_packet(16'd5, 8'd55, 16'h0505);
    send_packet(16'd4, 8'd44, 16'h0404);
    go_idle();
    write_reg(REG_LAST_SEQ, 16'd4);
    send_packet(16'd3, 8'd33, 16'h0303);
    send_packet(16'd5, 8'd56, 16'h0506);
    go_idle();
    write_reg(REG_SPARE_A, 16'h0001);
    write_reg(REG_SPARE_B, 16'hFFFF);
    write_reg(REG_LAST_SEQ, 16'd100);
    // a duplicate still drives the release of the held run
    send_packet(16'd4, 8'd1, 16'h0444);
    go_idle();
  endtask

  task automatic test_random_traffic(input int goal);
    logic [SEQ_W-1:0] order[$];
    logic [SEQ_W-1:0] tmp;
    logic [SEQ_W-1:0] s;
    logic [SIZE_W-1:0] sz;
    int sent;
    int phase;
    int span;
    int k;
    int j;
    int pick;
    sent = 0;
    phase = 0;
    while (sent < goal) begin
      go_idle();
      if (phase == 0) begin
        write_reg(REG_WINDOW_SIZE, 16'd16);
        write_reg(REG_LAST_SEQ, 16'(base_seq + 40));
      end else begin
        case ($urandom_range(4))
          0: write_reg(REG_WINDOW_SIZE, 16'd0);
          1: write_reg(REG_WINDOW_SIZE, 16'd1);
          2: write_reg(REG_WINDOW_SIZE, 16'd16);
          3: write_reg(REG_WINDOW_SIZE, 16'd31);
          default: write_reg(REG_WINDOW_SIZE, 16'($urandom_range(0, 65535)));
        endcase
        pick = $urandom_range(7);
        if (pick == 0) write_reg(REG_LAST_SEQ, 16'hFFFF);
        else if (pick == 1 && base_seq > 0)
          write_reg(REG_LAST_SEQ, 16'($urandom_range(0, base_seq - 1)));
        else write_reg(REG_LAST_SEQ, 16'(base_seq + $urandom_range(0, 48)));
      end
      span = window_span(win_cfg);
      k = (phase == 0) ? span : $urandom_range(1, span);
      order = {};
      for (j = 1; j < k; j++) order.push_back(16'(base_seq + j));
      for (j = order.size() - 1; j > 0; j--) begin
        pick = $urandom_range(0, j);
        tmp = order[j];
        order[j] = order[pick];
        order[pick] = tmp;
      end
      // sent last, the base releases the whole stored run at once; else it goes anywhere
      if (phase == 0 || $urandom_range(1) == 0) order.push_back(base_seq[SEQ_W-1:0]);
      else order.insert($urandom_range(0, order.size()), base_seq[SEQ_W-1:0]);
      foreach (order[pos]) begin
        s = order[pos];
        if ($urandom_range(99) < 20) begin
          case ($urandom_range(3))
            0: s = 16'($urandom_range(0, 65535));
            1: s = (base_seq == 0) ? 16'd0 : 16'($urandom_range(0, base_seq - 1));
            2: s = 16'(base_seq + span + $urandom_range(0, 3));
            default: s = order[$urandom_range(0, order.size() - 1)];
          endcase
          send_packet(s, 8'($urandom_range(0, 128)), 16'($urandom_range(0, 65535)));
          sent++;
          s = order[pos];
        end
        if ($urandom_range(99) < 10) sz = 8'($urandom_range(129, 255));
        else sz = 8'($urandom_range(0, 128));
        send_packet(s, sz, 16'($urandom_range(0, 65535)));
        sent++;
      end
      phase++;
      calm = (phase >= 4 && phase < 8);
    end
    calm = 1'b0;
  endtask

  initial begin
    win_cfg = WINDOW_SIZE_RST;
    last_cfg = LAST_SEQ_RST;
    base_seq = '0;
    foreach (held[i]) held[i] = 1'b0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_window_limits();
    test_last_seq_lowered();
    test_random_traffic(115);
    go_idle();
    repeat (20) @(posedge clk);
    if (mismatches == 0) $display("simulation ok");
    else $display("simulation failed");
    $finish;
  end

endmodule
